// File: hdl/polynomial_roots_newton_deflation_defines.svh
// ----------------------------------------------------------------------------
// Polynomial root finder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ROOTS_NEWTON_DEFLATION_DEFINES_SVH
`define POLYNOMIAL_ROOTS_NEWTON_DEFLATION_DEFINES_SVH

// Same-cycle implication.
`define PRND_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prnd check failed");

// Next-cycle implication.
`define PRND_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prnd check failed");

`endif

// File: hdl/prnd_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial root finder package
// Word format, beat types, codes and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package prnd_pkg;

  localparam int WORD_BITS    = 48;
  localparam int FRAC_BITS    = 32;
  localparam int MAX_DEGREE   = 15;
  localparam int DEG_BITS     = 4;
  localparam int ITER_BITS    = 8;
  localparam int TOL_BITS     = 32;
  localparam int ADDR_BITS    = 4;
  localparam int HALF_BITS    = WORD_BITS / 2;
  localparam int PROD_BITS    = 2 * WORD_BITS;
  localparam int QUO_BITS     = WORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic [DEG_BITS-1:0]         deg_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_START = 1'b1;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NO_CONV  = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV = 2'd2;

  localparam logic [1:0] REG_DEGREE   = 2'd0;
  localparam logic [1:0] REG_MAX_ITER = 2'd1;
  localparam logic [1:0] REG_TOL      = 2'd2;

  typedef struct packed {
    logic  action;
    deg_t  coef_index;
    word_t value;
  } in_item_t;

  typedef struct packed {
    deg_t       root_index;
    word_t      root_value;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic neg;
    mag_t a;
    mag_t b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic neg;
    mag_t n;
    mag_t d;
  } div_req_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic mag_t mag(word_t a);
    return a[WORD_BITS-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

  // Clamp a magnitude to the signed range and apply the sign.
  function automatic word_t from_mag(logic neg, logic [PROD_BITS-1:0] m);
    logic [PROD_BITS-1:0] lim;
    logic [PROD_BITS-1:0] v;
    word_t r;
    lim = neg ? (PROD_BITS'(1) << (WORD_BITS-1)) : PROD_BITS'(WMAX);
    v = (m > lim) ? lim : m;
    r = word_t'(v[WORD_BITS-1:0]);
    return neg ? word_t'(-r) : r;
  endfunction

  // k*a with saturation; equals k repeated saturating additions.
  function automatic word_t kmul(word_t a, deg_t k);
    logic signed [WORD_BITS+DEG_BITS:0] p;
    p = a * $signed({1'b0, k});
    if (p[WORD_BITS+DEG_BITS:WORD_BITS-1] != {(DEG_BITS+2){p[WORD_BITS+DEG_BITS]}})
      return p[WORD_BITS+DEG_BITS] ? WMIN : WMAX;
    return word_t'(p[WORD_BITS-1:0]);
  endfunction

endpackage

// File: hdl/prnd_coef_ram.sv
// ----------------------------------------------------------------------------
// Coefficient store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prnd_coef_ram (
  input  logic                  clk,
  input  logic                  we,
  input  prnd_pkg::deg_t        waddr,
  input  prnd_pkg::word_t       wdata,
  input  prnd_pkg::deg_t        raddr,
  output prnd_pkg::word_t       rdata
);

  prnd_pkg::word_t mem [0:prnd_pkg::MAX_DEGREE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/prnd_mul.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Magnitude product from four half-width partial products, one per cycle.
// ----------------------------------------------------------------------------
module prnd_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  prnd_pkg::mul_req_t                 req,
  output logic                               done,
  output logic [prnd_pkg::PROD_BITS-1:0]     prod,
  output prnd_pkg::word_t                    q
);

  localparam int H = prnd_pkg::HALF_BITS;

  prnd_pkg::mag_t              a_r;
  prnd_pkg::mag_t              b_r;
  logic                        neg_r;
  logic                        busy;
  logic [2:0]                  cnt;
  logic [1:0]                  sh_r;
  logic [2*H-1:0]              pp;
  logic [prnd_pkg::PROD_BITS-1:0] acc;
  logic [prnd_pkg::PROD_BITS-1:0] pp_sh;
  logic [H-1:0]                op_a;
  logic [H-1:0]                op_b;

  assign op_a = cnt[1] ? a_r[2*H-1:H] : a_r[H-1:0];
  assign op_b = cnt[0] ? b_r[2*H-1:H] : b_r[H-1:0];

  always_comb begin
    unique case (sh_r)
      2'd0:    pp_sh = prnd_pkg::PROD_BITS'(pp);
      2'd3:    pp_sh = prnd_pkg::PROD_BITS'(pp) << (2*H);
      default: pp_sh = prnd_pkg::PROD_BITS'(pp) << H;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        a_r   <= req.a;
        b_r   <= req.b;
        neg_r <= req.neg;
        acc   <= '0;
      end else if (busy) begin
        if (cnt != 3'd0) begin
          acc <= acc + pp_sh;
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          pp   <= op_a * op_b;
          sh_r <= cnt[1:0];
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign prod = acc;
  assign q    = prnd_pkg::from_mag(neg_r, acc >> prnd_pkg::FRAC_BITS);

endmodule

// File: hdl/prnd_div.sv
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring division of (n << FRAC_BITS) by d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prnd_div (
  input  logic               clk,
  input  logic               rst,
  input  prnd_pkg::div_req_t req,
  output logic               done,
  output prnd_pkg::word_t    q
);

  localparam int W = prnd_pkg::WORD_BITS;
  localparam int QB = prnd_pkg::QUO_BITS;

  logic [QB-1:0]                     nq;
  prnd_pkg::mag_t                    rem;
  prnd_pkg::mag_t                    d_r;
  logic                              neg_r;
  logic                              busy;
  logic [prnd_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [W:0]                        rem_sh;
  logic [W:0]                        rem_sub;
  logic                              fits;

  assign rem_sh  = {rem, nq[QB-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign fits    = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= prnd_pkg::DIV_CNT_BITS'(QB);
        nq    <= {req.n, {prnd_pkg::FRAC_BITS{1'b0}}};
        rem   <= '0;
        d_r   <= req.d;
        neg_r <= req.neg;
      end else if (busy) begin
        rem <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
        nq  <= {nq[QB-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == prnd_pkg::DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q = prnd_pkg::from_mag(neg_r, prnd_pkg::PROD_BITS'(nq));

endmodule

// File: hdl/polynomial_roots_newton_deflation.sv
// ----------------------------------------------------------------------------
// Polynomial root finder, Newton-Raphson with deflation
// Loads Q15.32 coefficients, then solves for all real roots from one guess.
// ----------------------------------------------------------------------------
// Load beats write one coefficient each; a start beat runs the whole solve
// before the next item beat is taken. Each Newton update at degree m is a
// Horner pass that reads the coefficient store once per term and runs two
// multiplies per term but the last, which runs one, then a bit-serial divide
// and one tolerance multiply. Deflation follows each root found, and the last
// root takes one more divide. Roots leave through an output register as they
// are found, so the solve only holds when a second root is ready before the
// first beat is taken.
module polynomial_roots_newton_deflation (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  prnd_pkg::in_item_t      item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output prnd_pkg::out_item_t     result,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [prnd_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int W = prnd_pkg::WORD_BITS;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_EMIT     = 5'd1;
  localparam logic [4:0] S_N_START  = 5'd2;
  localparam logic [4:0] S_H_TOP    = 5'd3;
  localparam logic [4:0] S_H_DATA   = 5'd4;
  localparam logic [4:0] S_H_M1     = 5'd5;
  localparam logic [4:0] S_H_M2     = 5'd6;
  localparam logic [4:0] S_DIV      = 5'd7;
  localparam logic [4:0] S_DIV_W    = 5'd8;
  localparam logic [4:0] S_CONV     = 5'd9;
  localparam logic [4:0] S_DF_START = 5'd10;
  localparam logic [4:0] S_DF_TOP   = 5'd11;
  localparam logic [4:0] S_DF_DATA  = 5'd12;
  localparam logic [4:0] S_DF_M     = 5'd13;
  localparam logic [4:0] S_LAST1    = 5'd14;
  localparam logic [4:0] S_LAST0    = 5'd15;
  localparam logic [4:0] S_LAST_W   = 5'd16;

  // Configuration registers.
  prnd_pkg::deg_t                  degree;
  logic [prnd_pkg::ITER_BITS-1:0]  max_iter;
  logic [prnd_pkg::TOL_BITS-1:0]   tol;

  // Sequencer state.
  logic [4:0]                      state;
  logic [4:0]                      ret;
  logic                            wait_rd;
  prnd_pkg::deg_t                  m;
  prnd_pkg::deg_t                  k;
  logic [prnd_pkg::ITER_BITS-1:0]  iter;
  prnd_pkg::word_t                 guess;
  prnd_pkg::word_t                 xr;
  prnd_pkg::word_t                 fx;
  prnd_pkg::word_t                 fdx;
  prnd_pkg::word_t                 t;
  prnd_pkg::word_t                 carry;
  prnd_pkg::mag_t                  md;
  prnd_pkg::out_item_t             e_item;

  // Store ports.
  logic                            we;
  prnd_pkg::deg_t                  waddr;
  prnd_pkg::word_t                 wdata;
  prnd_pkg::deg_t                  raddr;
  prnd_pkg::word_t                 rdata;

  // Arithmetic units.
  prnd_pkg::mul_req_t              mreq;
  logic                            mdone;
  logic [prnd_pkg::PROD_BITS-1:0]  mprod;
  prnd_pkg::word_t                 mq;
  prnd_pkg::div_req_t              dreq;
  logic                            ddone;
  prnd_pkg::word_t                 dq;

  prnd_pkg::word_t                 xr_new;
  prnd_pkg::mag_t                  md_new;
  prnd_pkg::word_t                 neg_a0;
  logic                            conv;

  prnd_coef_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  prnd_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .prod (mprod),
    .q    (mq)
  );

  prnd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .q    (dq)
  );

  function automatic prnd_pkg::out_item_t mk_item(prnd_pkg::deg_t idx, prnd_pkg::word_t v,
                                                  logic [1:0] st, logic lst);
    prnd_pkg::out_item_t r;
    r.root_index = idx;
    r.root_value = v;
    r.status     = st;
    r.last       = lst;
    return r;
  endfunction

  // Newton update and its convergence distance.
  assign xr_new = prnd_pkg::sat_sub(guess, dq);
  assign md_new = prnd_pkg::mag(prnd_pkg::sat_sub(xr_new, guess));
  // Tolerance test without division: |x'-x| * 2^32 <= tol * |x'|.
  assign conv   = {md, {prnd_pkg::FRAC_BITS{1'b0}}} <= mprod[prnd_pkg::QUO_BITS-1:0];
  assign neg_a0 = prnd_pkg::sat_sub('0, rdata);

  assign item_ready = (state == S_IDLE);
  assign pready     = 1'b1;

  // Configuration port: write on the access phase, read back any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      degree   <= prnd_pkg::DEG_BITS'(2);
      max_iter <= prnd_pkg::ITER_BITS'(50);
      tol      <= prnd_pkg::TOL_BITS'(4295);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        prnd_pkg::REG_DEGREE:   degree   <= pwdata[prnd_pkg::DEG_BITS-1:0];
        prnd_pkg::REG_MAX_ITER: max_iter <= pwdata[prnd_pkg::ITER_BITS-1:0];
        prnd_pkg::REG_TOL:      tol      <= pwdata[prnd_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      prnd_pkg::REG_DEGREE:   prdata = 32'(degree);
      prnd_pkg::REG_MAX_ITER: prdata = 32'(max_iter);
      prnd_pkg::REG_TOL:      prdata = 32'(tol);
      default:                prdata = '0;
    endcase
  end

  // Solve sequencer. Every store read is issued with wait_rd set; the data
  // states first clear wait_rd, letting the registered read land, then use rdata.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      we           <= 1'b0;
      mreq.start   <= 1'b0;
      dreq.start   <= 1'b0;
      wait_rd      <= 1'b0;
      m            <= '0;
      iter         <= '0;
      guess        <= '0;
      fx           <= '0;
      fdx          <= '0;
    end else begin
      we         <= 1'b0;
      mreq.start <= 1'b0;
      dreq.start <= 1'b0;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.action == prnd_pkg::ACT_LOAD) begin
              we    <= 1'b1;
              waddr <= item.coef_index;
              wdata <= item.value;
            end else if (degree == '0) begin
              e_item <= mk_item('0, '0, prnd_pkg::ST_ZERO_DIV, 1'b1);
              ret    <= S_IDLE;
              state  <= S_EMIT;
            end else begin
              m     <= degree;
              guess <= item.value;
              if (degree >= prnd_pkg::DEG_BITS'(2)) begin
                state <= S_N_START;
              end else begin
                raddr   <= prnd_pkg::DEG_BITS'(1);
                wait_rd <= 1'b1;
                state   <= S_LAST1;
              end
            end
          end
        end
        S_EMIT: begin
          // Hold the beat until the output register frees up.
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            result       <= e_item;
            state        <= ret;
          end
        end
        S_N_START: begin
          iter <= '0;
          if (max_iter == '0) begin
            e_item <= mk_item('0, '0, prnd_pkg::ST_NO_CONV, 1'b1);
            ret    <= S_IDLE;
            state  <= S_EMIT;
          end else begin
            raddr   <= m;
            wait_rd <= 1'b1;
            state   <= S_H_TOP;
          end
        end
        S_H_TOP: begin
          if (wait_rd) begin
            wait_rd <= 1'b0;
          end else begin
            fx      <= rdata;
            fdx     <= prnd_pkg::kmul(rdata, m);
            k       <= m - 1'b1;
            raddr   <= m - 1'b1;
            wait_rd <= 1'b1;
            state   <= S_H_DATA;
          end
        end
        S_H_DATA: begin
          if (wait_rd) begin
            wait_rd <= 1'b0;
          end else begin
            t     <= rdata;
            mreq  <= '{start: 1'b1, neg: fx[W-1] ^ guess[W-1],
                       a: prnd_pkg::mag(fx), b: prnd_pkg::mag(guess)};
            state <= S_H_M1;
          end
        end
        S_H_M1: begin
          if (mdone) begin
            fx <= prnd_pkg::sat_add(mq, t);
            if (k != '0) begin
              mreq  <= '{start: 1'b1, neg: fdx[W-1] ^ guess[W-1],
                         a: prnd_pkg::mag(fdx), b: prnd_pkg::mag(guess)};
              state <= S_H_M2;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_H_M2: begin
          if (mdone) begin
            fdx     <= prnd_pkg::sat_add(mq, prnd_pkg::kmul(t, k));
            k       <= k - 1'b1;
            raddr   <= k - 1'b1;
            wait_rd <= 1'b1;
            state   <= S_H_DATA;
          end
        end
        S_DIV: begin
          if (fdx == '0) begin
            e_item <= mk_item('0, '0, prnd_pkg::ST_ZERO_DIV, 1'b1);
            ret    <= S_IDLE;
            state  <= S_EMIT;
          end else begin
            dreq  <= '{start: 1'b1, neg: fx[W-1] ^ fdx[W-1],
                       n: prnd_pkg::mag(fx), d: prnd_pkg::mag(fdx)};
            state <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (ddone) begin
            xr    <= xr_new;
            md    <= md_new;
            iter  <= iter + 1'b1;
            mreq  <= '{start: 1'b1, neg: 1'b0,
                       a: prnd_pkg::mag_t'(tol), b: prnd_pkg::mag(xr_new)};
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (mdone) begin
            // Advance the guess whether or not the root is accepted.
            guess <= xr;
            if (conv) begin
              e_item <= mk_item(m, xr, prnd_pkg::ST_FOUND, 1'b0);
              ret    <= S_DF_START;
              state  <= S_EMIT;
            end else if (iter < max_iter) begin
              raddr   <= m;
              wait_rd <= 1'b1;
              state   <= S_H_TOP;
            end else begin
              e_item <= mk_item('0, '0, prnd_pkg::ST_NO_CONV, 1'b1);
              ret    <= S_IDLE;
              state  <= S_EMIT;
            end
          end
        end
        S_DF_START: begin
          raddr   <= m;
          wait_rd <= 1'b1;
          state   <= S_DF_TOP;
        end
        S_DF_TOP: begin
          if (wait_rd) begin
            wait_rd <= 1'b0;
          end else begin
            // Drop the top coefficient and start the synthetic division.
            carry   <= rdata;
            we      <= 1'b1;
            waddr   <= m;
            wdata   <= '0;
            k       <= m - 1'b1;
            raddr   <= m - 1'b1;
            wait_rd <= 1'b1;
            state   <= S_DF_DATA;
          end
        end
        S_DF_DATA: begin
          if (wait_rd) begin
            wait_rd <= 1'b0;
          end else begin
            t     <= rdata;
            we    <= 1'b1;
            waddr <= k;
            wdata <= carry;
            mreq  <= '{start: 1'b1, neg: guess[W-1] ^ carry[W-1],
                       a: prnd_pkg::mag(guess), b: prnd_pkg::mag(carry)};
            state <= S_DF_M;
          end
        end
        S_DF_M: begin
          if (mdone) begin
            carry <= prnd_pkg::sat_add(t, mq);
            if (k == '0) begin
              m <= m - 1'b1;
              if (m - 1'b1 >= prnd_pkg::DEG_BITS'(2)) begin
                state <= S_N_START;
              end else begin
                raddr   <= prnd_pkg::DEG_BITS'(1);
                wait_rd <= 1'b1;
                state   <= S_LAST1;
              end
            end else begin
              k       <= k - 1'b1;
              raddr   <= k - 1'b1;
              wait_rd <= 1'b1;
              state   <= S_DF_DATA;
            end
          end
        end
        S_LAST1: begin
          if (wait_rd) begin
            wait_rd <= 1'b0;
          end else begin
            t       <= rdata;
            raddr   <= '0;
            wait_rd <= 1'b1;
            state   <= S_LAST0;
          end
        end
        S_LAST0: begin
          if (wait_rd) begin
            wait_rd <= 1'b0;
          end else if (t == '0) begin
            e_item <= mk_item('0, '0, prnd_pkg::ST_ZERO_DIV, 1'b1);
            ret    <= S_IDLE;
            state  <= S_EMIT;
          end else begin
            // Last root is -a0/a1.
            dreq  <= '{start: 1'b1, neg: neg_a0[W-1] ^ t[W-1],
                       n: prnd_pkg::mag(neg_a0), d: prnd_pkg::mag(t)};
            state <= S_LAST_W;
          end
        end
        S_LAST_W: begin
          if (ddone) begin
            e_item <= mk_item(prnd_pkg::DEG_BITS'(1), dq, prnd_pkg::ST_FOUND, 1'b1);
            ret    <= S_IDLE;
            state  <= S_EMIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/prnd_checker.sv
// ----------------------------------------------------------------------------
// Polynomial root finder checker
// Port-level checks on the item and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "polynomial_roots_newton_deflation_defines.svh"

module prnd_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input prnd_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_ready,
  input prnd_pkg::out_item_t result
);

  // A stalled result beat holds.
  `PRND_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
  `PRND_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result))

  // A start beat takes the block busy.
  `PRND_ASSERT_NEXT(a_start_busy,
    item_valid && item_ready && item.action == prnd_pkg::ACT_START, !item_ready)

  // A failure beat closes the solve and carries no root number.
  `PRND_ASSERT_IMPL(a_fail_ends, result_valid && result.status != prnd_pkg::ST_FOUND,
    result.last && result.root_index == '0)

endmodule

bind polynomial_roots_newton_deflation prnd_checker u_prnd_checker (.*);
